FILE: hw/rtl/rstpu_pkg.sv
// shared constants and command/status types for the range-sum tree
package rstpu_pkg;

  localparam int DEFAULT_SIZE = 1024;
  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  typedef struct packed {
    logic clr_step;
    logic latch;
    logic q_read_l;
    logic q_acc_l;
    logic q_read_r;
    logic q_acc_r;
    logic q_shift;
    logic u_init;
    logic u_read;
    logic u_write;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic upd_ok;
    logic p_gt1;
  } sts_t;

endpackage

FILE: hw/rtl/rstpu_ctrl.sv
// controller state machine sequencing clear, span query and path update
module rstpu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              req_type,
  input  rstpu_pkg::sts_t   sts,
  output rstpu_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              done
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_QL    = 4'd2;
  localparam logic [3:0] S_QLA   = 4'd3;
  localparam logic [3:0] S_QR    = 4'd4;
  localparam logic [3:0] S_QRA   = 4'd5;
  localparam logic [3:0] S_QDONE = 4'd6;
  localparam logic [3:0] S_UINIT = 4'd7;
  localparam logic [3:0] S_UREAD = 4'd8;
  localparam logic [3:0] S_UWRT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_next = req_type ? S_QL : S_UINIT;
        end
      end
      S_QL: begin
        if (sts.l_lt_r) begin
          if (sts.l_odd) begin
            cmd.q_read_l = 1'b1;
            state_next = S_QLA;
          end else begin
            state_next = S_QR;
          end
        end else begin
          state_next = S_QDONE;
        end
      end
      S_QLA: begin
        cmd.q_acc_l = 1'b1;
        state_next = S_QR;
      end
      S_QR: begin
        if (sts.r_odd) begin
          cmd.q_read_r = 1'b1;
          state_next = S_QRA;
        end else begin
          cmd.q_shift = 1'b1;
          state_next = S_QL;
        end
      end
      S_QRA: begin
        cmd.q_acc_r = 1'b1;
        cmd.q_shift = 1'b1;
        state_next = S_QL;
      end
      S_QDONE: begin
        state_next = S_UINIT;
      end
      S_UINIT: begin
        if (sts.upd_ok) begin
          cmd.u_init = 1'b1;
          state_next = S_UREAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_UREAD: begin
        if (sts.p_gt1) begin
          cmd.u_read = 1'b1;
          state_next = S_UWRT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_UWRT: begin
        cmd.u_write = 1'b1;
        state_next = S_UREAD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_QDONE);

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy clearing after reset");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");
  a_done_then_update: assert property (@(posedge clk) disable iff (rst)
    done |=> (busy && !done))
    else $error("result not followed by update phase");
`endif

endmodule

FILE: hw/rtl/rstpu_dp.sv
// datapath: node memory, span pointers, accumulator and update path
module rstpu_dp #(
  parameter int SIZE = rstpu_pkg::DEFAULT_SIZE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rstpu_pkg::cmd_t                     cmd,
  output rstpu_pkg::sts_t                     sts,
  input  logic [rstpu_pkg::POS_W-1:0]         first_pos,
  input  logic [rstpu_pkg::POS_W-1:0]         second_pos,
  input  logic [rstpu_pkg::POS_W-1:0]         upd_pos,
  input  logic signed [rstpu_pkg::VAL_W-1:0]  new_value,
  output logic signed [rstpu_pkg::SUM_W-1:0]  range_sum
);

  localparam int AW = $clog2(2 * SIZE);
  localparam int CW = AW + 1;
  localparam int DEPTH = 2 * SIZE;
  localparam logic [31:0] SIZE32 = 32'(SIZE);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  logic [rstpu_pkg::SUM_W-1:0] mem [DEPTH];
  logic [rstpu_pkg::SUM_W-1:0] rdata;
  logic [rstpu_pkg::SUM_W-1:0] acc;
  logic [rstpu_pkg::SUM_W-1:0] carry;
  logic [AW-1:0] cnt;
  logic [CW-1:0] l;
  logic [CW-1:0] r;
  logic [AW-1:0] p;
  logic [31:0] upd_leaf;
  logic [rstpu_pkg::VAL_W-1:0] val;
  logic upd_ok;

  logic [31:0] a32, b32, lo32, hi32, hic32;
  logic empty;
  logic [CW-1:0] l_init, r_init;
  logic [CW-1:0] r_dec;
  logic [rstpu_pkg::SUM_W-1:0] parent_sum;
  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [rstpu_pkg::SUM_W-1:0] wdata;

  always_comb begin
    a32 = 32'(first_pos);
    b32 = 32'(second_pos);
    lo32 = (a32 <= b32) ? a32 : b32;
    hi32 = (a32 <= b32) ? b32 : a32;
    empty = (lo32 >= SIZE32);
    hic32 = (hi32 >= SIZE32) ? (SIZE32 - 32'd1) : hi32;
    l_init = empty ? '0 : CW'(lo32 + SIZE32);
    r_init = empty ? '0 : CW'(hic32 + SIZE32 + 32'd1);
  end

  assign r_dec = r - CW'(1);
  assign parent_sum = carry + rdata;

  always_comb begin
    we = 1'b0;
    waddr = cnt;
    wdata = '0;
    re = 1'b0;
    raddr = l[AW-1:0];
    priority if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.u_init) begin
      we = 1'b1;
      waddr = AW'(upd_leaf);
      wdata = {{(rstpu_pkg::SUM_W - rstpu_pkg::VAL_W){val[rstpu_pkg::VAL_W-1]}}, val};
    end else if (cmd.u_write) begin
      we = 1'b1;
      waddr = p >> 1;
      wdata = parent_sum;
    end else if (cmd.q_read_l) begin
      re = 1'b1;
    end else if (cmd.q_read_r) begin
      re = 1'b1;
      raddr = r_dec[AW-1:0];
    end else if (cmd.u_read) begin
      re = 1'b1;
      raddr = p ^ AW'(1);
    end else begin
      re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr_step) begin
      cnt <= cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      l <= l_init;
      r <= r_init;
      acc <= '0;
      val <= new_value;
      upd_ok <= (32'(upd_pos) < SIZE32);
      upd_leaf <= 32'(upd_pos) + SIZE32;
    end else begin
      if (cmd.q_acc_l) begin
        l <= l + CW'(1);
      end
      if (cmd.q_read_r) begin
        r <= r_dec;
      end
      if (cmd.q_shift) begin
        l <= l >> 1;
        r <= r >> 1;
      end
      if (cmd.q_acc_l || cmd.q_acc_r) begin
        acc <= acc + rdata;
      end
    end
    if (cmd.u_init) begin
      p <= AW'(upd_leaf);
      carry <= {{(rstpu_pkg::SUM_W - rstpu_pkg::VAL_W){val[rstpu_pkg::VAL_W-1]}}, val};
    end else if (cmd.u_write) begin
      p <= p >> 1;
      carry <= parent_sum;
    end
  end

  always_comb begin
    sts.clr_last = (cnt == CLR_LAST);
    sts.l_lt_r = (l < r);
    sts.l_odd = l[0];
    sts.r_odd = r[0];
    sts.upd_ok = upd_ok;
    sts.p_gt1 = (p > AW'(1));
  end

  assign range_sum = acc;

`ifndef ASSERT_OFF
  a_write_parent: assert property (@(posedge clk) disable iff (rst)
    cmd.u_write |-> (p > AW'(1)))
    else $error("parent write above the root");
  a_read_left: assert property (@(posedge clk) disable iff (rst)
    cmd.q_read_l |-> (l[0] && (l < r)))
    else $error("left read outside span");
  a_acc_after_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.q_acc_l || cmd.q_acc_r) |-> ($past(cmd.q_read_l) || $past(cmd.q_read_r)))
    else $error("accumulate without a node read");
`endif

endmodule

FILE: hw/rtl/range_sum_tree_point_update.sv
// top level of the range-sum tree with point update
// a load keeps busy high after the transfer while it writes the leaf and then each parent up to the root
// a query walks the tree one level at a time, at most two node reads a level, then updates
// one item is worked at a time
// done is shown for one cycle and range_sum holds until the next transfer; the receiver cannot stall
// after rst the node memory is cleared while busy is high
module range_sum_tree_point_update #(
  parameter int SIZE = rstpu_pkg::DEFAULT_SIZE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [rstpu_pkg::POS_W-1:0]         first_pos,
  input  logic [rstpu_pkg::POS_W-1:0]         second_pos,
  input  logic [rstpu_pkg::POS_W-1:0]         upd_pos,
  input  logic signed [rstpu_pkg::VAL_W-1:0]  new_value,
  output logic                                done,
  output logic signed [rstpu_pkg::SUM_W-1:0]  range_sum
);

  rstpu_pkg::cmd_t cmd;
  rstpu_pkg::sts_t sts;

  rstpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  rstpu_dp #(
    .SIZE (SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .first_pos  (first_pos),
    .second_pos (second_pos),
    .upd_pos    (upd_pos),
    .new_value  (new_value),
    .range_sum  (range_sum)
  );

endmodule
